// File: rtl/serial_command_decoder_core_defines.svh
// assertion macros used by the serial command decoder rtl
`ifndef SERIAL_COMMAND_DECODER_CORE_DEFINES_SVH
`define SERIAL_COMMAND_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define SCD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("serial command decoder check failed");

// implication with the consequent in the next cycle
`define SCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("serial command decoder sequencing check failed");

`else

`define SCD_ASSERT(lbl, clk, rstn, prop)
`define SCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/scd_pkg.sv
// types, codes and the segment table of the serial command decoder
`timescale 1ns / 1ps

package scd_pkg;

    // grammar positions
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_L     = 4'd1;
    localparam logic [3:0] ST_LS    = 4'd2;
    localparam logic [3:0] ST_LC    = 4'd3;
    localparam logic [3:0] ST_S     = 4'd4;
    localparam logic [3:0] ST_D     = 4'd5;
    localparam logic [3:0] ST_DN    = 4'd6;
    localparam logic [3:0] ST_LCD   = 4'd7;
    localparam logic [3:0] ST_LCDO  = 4'd8;
    localparam logic [3:0] ST_LCDOF = 4'd9;

    // response codes
    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_ACK  = 2'd1;
    localparam logic [1:0] RESP_ERR  = 2'd2;

    // ascii characters of the grammar
    localparam logic [7:0] CHR_C     = 8'h43;
    localparam logic [7:0] CHR_D     = 8'h44;
    localparam logic [7:0] CHR_F     = 8'h46;
    localparam logic [7:0] CHR_L     = 8'h4C;
    localparam logic [7:0] CHR_N     = 8'h4E;
    localparam logic [7:0] CHR_O     = 8'h4F;
    localparam logic [7:0] CHR_S     = 8'h53;
    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_1     = 8'h31;
    localparam logic [7:0] CHR_3     = 8'h33;
    localparam logic [7:0] CHR_4     = 8'h34;
    localparam logic [7:0] CHR_9     = 8'h39;

    typedef struct packed {
        logic [3:0] parse_state;
        logic [1:0] chosen_display;
        logic       led_level;
        logic [3:0] enables_held;
        logic [6:0] pattern_held;
        logic       lcd_flag;
    } scd_state_t;

    // segments a..g in bits 0..6
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'b0111111;
            4'd1:    pat = 7'b0000110;
            4'd2:    pat = 7'b1011011;
            4'd3:    pat = 7'b1001111;
            4'd4:    pat = 7'b1100110;
            4'd5:    pat = 7'b1101101;
            4'd6:    pat = 7'b1111101;
            4'd7:    pat = 7'b0100111;
            4'd8:    pat = 7'b1111111;
            4'd9:    pat = 7'b1101111;
            default: pat = 7'b0000000;
        endcase
        return pat;
    endfunction

endpackage

// File: rtl/serial_command_decoder_core.sv
// top level of the serial command decoder: state register and result register
`timescale 1ns / 1ps
`include "serial_command_decoder_core_defines.svh"

// Serial command decoder. Each received character is one input transfer and
// produces exactly one result transfer carrying the response code (none yet,
// acknowledge or error) and the current LED, display and LCD outputs. The
// grammar state and the held outputs update in the cycle a character is
// taken; the result appears on the m_ side in the next cycle. One character
// per cycle is sustained: s_ready stays high while the single result register
// is empty or its content is being taken in the same cycle, so the only limit
// is that result register waiting on m_ready.
module serial_command_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_response,
    output logic       m_led_on,
    output logic [3:0] m_digit_enable,
    output logic [6:0] m_segments,
    output logic       m_lcd_on
);

    scd_pkg::scd_state_t state_reg;
    scd_pkg::scd_state_t state_next;
    logic [1:0]          resp_next;
    logic                in_xfer;

    logic       m_valid_reg;
    logic [1:0] response_reg;
    logic       led_on_reg;
    logic [3:0] digit_enable_reg;
    logic [6:0] segments_reg;
    logic       lcd_on_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    scd_parser u_parser (
        .cur_state (state_reg),
        .rx_char   (s_rx_char),
        .nxt_state (state_next),
        .response  (resp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.parse_state    <= scd_pkg::ST_IDLE;
            state_reg.chosen_display <= 2'd0;
            state_reg.led_level      <= 1'b0;
            state_reg.enables_held   <= 4'd0;
            state_reg.pattern_held   <= 7'd0;
            state_reg.lcd_flag       <= 1'b1;
            m_valid_reg              <= 1'b0;
        end else begin
            if (in_xfer) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted character
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            response_reg     <= resp_next;
            led_on_reg       <= state_next.led_level;
            digit_enable_reg <= state_next.enables_held;
            segments_reg     <= state_next.pattern_held;
            lcd_on_reg       <= state_next.lcd_flag;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_response     = response_reg;
    assign m_led_on       = led_on_reg;
    assign m_digit_enable = digit_enable_reg;
    assign m_segments     = segments_reg;
    assign m_lcd_on       = lcd_on_reg;

    `SCD_ASSERT(a_enable_onehot, aclk, aresetn, m_valid_reg |-> $onehot0(m_digit_enable))
    `SCD_ASSERT(a_blank_together, aclk, aresetn,
        m_valid_reg |-> ((m_digit_enable == 4'd0) == (m_segments == 7'd0)))
    `SCD_ASSERT(a_resp_code, aclk, aresetn, m_valid_reg |-> (m_response != 2'd3))
    `SCD_ASSERT_NEXT(a_err_to_idle, aclk, aresetn,
        in_xfer && (resp_next == scd_pkg::RESP_ERR),
        state_reg.parse_state == scd_pkg::ST_IDLE)
    `SCD_ASSERT_NEXT(a_ack_to_idle, aclk, aresetn,
        in_xfer && (resp_next == scd_pkg::RESP_ACK),
        (state_reg.parse_state == scd_pkg::ST_IDLE) && (m_response == scd_pkg::RESP_ACK))

endmodule

// File: rtl/scd_parser.sv
// next-state and response logic of the command grammar
`timescale 1ns / 1ps

module scd_parser (
    input  scd_pkg::scd_state_t cur_state,
    input  logic [7:0]          rx_char,
    output scd_pkg::scd_state_t nxt_state,
    output logic [1:0]          response
);

    logic [1:0] disp_off;
    logic [3:0] digit_off;
    logic       is_disp;
    logic       is_digit;

    assign disp_off  = 2'(rx_char - scd_pkg::CHR_1);
    assign digit_off = 4'(rx_char - scd_pkg::CHR_0);
    assign is_disp   = (rx_char >= scd_pkg::CHR_1) && (rx_char <= scd_pkg::CHR_4);
    assign is_digit  = (rx_char >= scd_pkg::CHR_0) && (rx_char <= scd_pkg::CHR_9);

    always_comb begin
        nxt_state             = cur_state;
        nxt_state.parse_state = scd_pkg::ST_IDLE;
        response              = scd_pkg::RESP_ERR;
        case (cur_state.parse_state)
            scd_pkg::ST_L: begin
                if (rx_char == scd_pkg::CHR_S) begin
                    nxt_state.parse_state = scd_pkg::ST_LS;
                    response              = scd_pkg::RESP_NONE;
                end else if (rx_char == scd_pkg::CHR_C) begin
                    nxt_state.parse_state = scd_pkg::ST_LC;
                    response              = scd_pkg::RESP_NONE;
                end
            end
            scd_pkg::ST_LS: begin
                if (rx_char == scd_pkg::CHR_4) begin
                    nxt_state.led_level = 1'b1;
                    response            = scd_pkg::RESP_ACK;
                end
            end
            scd_pkg::ST_LC: begin
                // "LC" is shared by the led command and the lcd commands
                if (rx_char == scd_pkg::CHR_4) begin
                    nxt_state.led_level = 1'b0;
                    response            = scd_pkg::RESP_ACK;
                end else if (rx_char == scd_pkg::CHR_D) begin
                    nxt_state.parse_state = scd_pkg::ST_LCD;
                    response              = scd_pkg::RESP_NONE;
                end
            end
            scd_pkg::ST_S: begin
                if (rx_char == scd_pkg::CHR_3) begin
                    response = scd_pkg::RESP_ACK;
                end
            end
            scd_pkg::ST_D: begin
                if (is_disp) begin
                    nxt_state.chosen_display = disp_off;
                    nxt_state.parse_state    = scd_pkg::ST_DN;
                    response                 = scd_pkg::RESP_NONE;
                end
            end
            scd_pkg::ST_DN: begin
                if (rx_char == scd_pkg::CHR_C) begin
                    nxt_state.enables_held = 4'd0;
                    nxt_state.pattern_held = 7'd0;
                    response               = scd_pkg::RESP_ACK;
                end else if (is_digit) begin
                    nxt_state.enables_held = 4'd1 << cur_state.chosen_display;
                    nxt_state.pattern_held = scd_pkg::seg_pattern(digit_off);
                    response               = scd_pkg::RESP_ACK;
                end
            end
            scd_pkg::ST_LCD: begin
                if (rx_char == scd_pkg::CHR_O) begin
                    nxt_state.parse_state = scd_pkg::ST_LCDO;
                    response              = scd_pkg::RESP_NONE;
                end
            end
            scd_pkg::ST_LCDO: begin
                if (rx_char == scd_pkg::CHR_N) begin
                    nxt_state.lcd_flag = 1'b1;
                    response           = scd_pkg::RESP_ACK;
                end else if (rx_char == scd_pkg::CHR_F) begin
                    nxt_state.parse_state = scd_pkg::ST_LCDOF;
                    response              = scd_pkg::RESP_NONE;
                end
            end
            scd_pkg::ST_LCDOF: begin
                if (rx_char == scd_pkg::CHR_F) begin
                    nxt_state.lcd_flag = 1'b0;
                    response           = scd_pkg::RESP_ACK;
                end
            end
            default: begin
                // idle, and any unused code behaves as idle
                if (rx_char == scd_pkg::CHR_L) begin
                    nxt_state.parse_state = scd_pkg::ST_L;
                    response              = scd_pkg::RESP_NONE;
                end else if (rx_char == scd_pkg::CHR_S) begin
                    nxt_state.parse_state = scd_pkg::ST_S;
                    response              = scd_pkg::RESP_NONE;
                end else if (rx_char == scd_pkg::CHR_D) begin
                    nxt_state.parse_state = scd_pkg::ST_D;
                    response              = scd_pkg::RESP_NONE;
                end
            end
        endcase
    end

endmodule
